// ===== rtl/core/smaa_pkg.sv =====
// shared types and codes for the sparse matrix assembly accumulator
package smaa_pkg;

    typedef struct packed {
        logic       storage_mode;
        logic       row_major;
        logic [6:0] order;
    } cfg_t;

    localparam logic [1:0] REG_STORAGE_MODE = 2'd0;
    localparam logic [1:0] REG_ROW_MAJOR    = 2'd1;
    localparam logic [1:0] REG_ORDER        = 2'd2;

    localparam logic [6:0] ORDER_RESET = 7'd64;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

endpackage

// ===== rtl/core/smaa_ram.sv =====
// single-port-write, single-port-read synchronous ram with registered read data
module smaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/smaa_cfg.sv =====
// apb configuration registers
module smaa_cfg
    import smaa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.storage_mode <= 1'b0;
            cfg_reg.row_major    <= 1'b0;
            cfg_reg.order        <= ORDER_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_STORAGE_MODE: cfg_reg.storage_mode <= pwdata[0];
                REG_ROW_MAJOR:    cfg_reg.row_major    <= pwdata[0];
                REG_ORDER:        cfg_reg.order        <= pwdata[6:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_STORAGE_MODE: prdata = {31'd0, cfg_reg.storage_mode};
            REG_ROW_MAJOR:    prdata = {31'd0, cfg_reg.row_major};
            REG_ORDER:        prdata = {25'd0, cfg_reg.order};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/sparse_matrix_assembly_accumulator_core.sv =====
// sparse/dense matrix accumulator: sequencer over link and value rams
// dense: dense then add state, or drop there; sparse: bad second index drops in idle, else head
// read, then walk and check per chain entry, then add, drop or append; a new entry keeps busy
// high through the link state after its result; clear item: one value ram entry zeroed per cycle
// after reset a clearing pass over all POOL_ENTRIES entries runs with busy high
// done pulses one cycle per item; the receiver cannot stall
module sparse_matrix_assembly_accumulator_core
    import smaa_pkg::*;
#(
    parameter int MAX_ORDER    = 64,
    parameter int POOL_ENTRIES = 4096,
    parameter int VALUE_BITS   = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [5:0]                   first_index,
    input  logic [5:0]                   second_index,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [11:0]                  slot,
    output logic signed [VALUE_BITS-1:0] total
);

    localparam int IDX_W      = $clog2(POOL_ENTRIES);
    localparam int LINK_W     = $clog2(POOL_ENTRIES + 1);
    localparam int HIDX_W     = $clog2(MAX_ORDER);
    localparam int LW         = 6 + LINK_W;
    localparam int LINK_DEPTH = POOL_ENTRIES + MAX_ORDER;
    localparam int LA_W       = $clog2(POOL_ENTRIES + MAX_ORDER);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_DENSE  = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_WCHK   = 4'd5;
    localparam logic [3:0] S_APPEND = 4'd6;
    localparam logic [3:0] S_LINK   = 4'd7;
    localparam logic [3:0] S_HEAD   = 4'd8;

    cfg_t cfg;

    smaa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [3:0]            state_reg, state_next;
    logic                  clr_emit_reg, clr_emit_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [LINK_W-1:0]     count_reg, count_next;
    logic [LINK_W-1:0]     link_reg, link_next;
    logic [LINK_W-1:0]     tail_reg, tail_next;
    logic [IDX_W-1:0]      ent_reg, ent_next;
    logic [5:0]            fi_reg, fi_next;
    logic [5:0]            si_reg, si_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [MAX_ORDER-1:0]  head_vld_reg;

    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;
    logic [11:0]           slot_reg, slot_next;
    logic [VALUE_BITS-1:0] total_reg, total_next;

    // head control, chain heads live above the pool in the link ram
    logic                  head_clr;
    logic                  head_set;
    logic [HIDX_W-1:0]     head_idx;
    logic [31:0]           si_w;
    logic [LA_W-1:0]       head_addr_in, head_addr;

    // rams
    logic                  lm_we, lm_re;
    logic [LA_W-1:0]       lm_waddr, lm_raddr;
    logic [LW-1:0]         lm_wdata, lm_rdata;
    logic                  vm_we, vm_re;
    logic [IDX_W-1:0]      vm_waddr, vm_raddr;
    logic [VALUE_BITS-1:0] vm_wdata, vm_rdata;

    logic [13:0]           daddr;
    logic [VALUE_BITS-1:0] sum;
    logic [31:0]           count_w, link_w, ent_w;

    function automatic logic [VALUE_BITS-1:0] sat_add(input logic [VALUE_BITS-1:0] a,
                                                      input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
        begin
            return s[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                 : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        return s[VALUE_BITS-1:0];
    endfunction

    smaa_ram #(.WIDTH(LW), .DEPTH(LINK_DEPTH), .AW(LA_W)) u_link_ram (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .re    (lm_re),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    smaa_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_ENTRIES), .AW(IDX_W)) u_value_ram (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .re    (vm_re),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    assign si_w         = 32'(si_reg);
    assign head_idx     = si_w[HIDX_W-1:0];
    assign head_addr_in = LA_W'(32'(POOL_ENTRIES) + 32'(second_index));
    assign head_addr    = LA_W'(32'(POOL_ENTRIES) + si_w);
    assign count_w      = 32'(count_reg);
    assign link_w       = 32'(link_reg - LINK_W'(1));
    assign ent_w        = 32'(ent_reg);

    // dense address from the latched indexes
    assign daddr = cfg.row_major ? 14'(14'(cfg.order) * 14'(si_reg)) + 14'(fi_reg)
                                 : 14'(14'(cfg.order) * 14'(fi_reg)) + 14'(si_reg);
    assign sum   = sat_add(vm_rdata, v_reg);

    always_comb
    begin
        state_next    = state_reg;
        clr_emit_next = clr_emit_reg;
        clr_cnt_next  = clr_cnt_reg;
        count_next    = count_reg;
        link_next     = link_reg;
        tail_next     = tail_reg;
        ent_next      = ent_reg;
        fi_next       = fi_reg;
        si_next       = si_reg;
        v_next        = v_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        slot_next     = slot_reg;
        total_next    = total_reg;
        head_clr      = 1'b0;
        head_set      = 1'b0;
        lm_we         = 1'b0;
        lm_re         = 1'b0;
        lm_waddr      = LA_W'(count_w[IDX_W-1:0]);
        lm_raddr      = LA_W'(link_w[IDX_W-1:0]);
        lm_wdata      = {fi_reg, {LINK_W{1'b0}}};
        vm_we         = 1'b0;
        vm_re         = 1'b0;
        vm_waddr      = clr_cnt_reg;
        vm_raddr      = link_w[IDX_W-1:0];
        vm_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    fi_next  = first_index;
                    si_next  = second_index;
                    v_next   = value;
                    tail_next = '0;
                    if (operation == OP_CLEAR)
                    begin
                        head_clr      = 1'b1;
                        count_next    = '0;
                        clr_cnt_next  = '0;
                        clr_emit_next = 1'b1;
                        state_next    = S_CLR;
                    end
                    else if (cfg.storage_mode)
                    begin
                        state_next = S_DENSE;
                    end
                    else if (32'(second_index) >= 32'(MAX_ORDER))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_DROPPED;
                        slot_next   = '0;
                        total_next  = '0;
                    end
                    else
                    begin
                        lm_re      = 1'b1;
                        lm_raddr   = head_addr_in;
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                // a chain never written since the last clear is empty
                link_next  = head_vld_reg[head_idx] ? lm_rdata[LINK_W-1:0] : '0;
                state_next = S_WALK;
            end
            S_CLR:
            begin
                vm_we    = 1'b1;
                vm_waddr = clr_cnt_reg;
                vm_wdata = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(POOL_ENTRIES - 1))
                begin
                    state_next    = S_IDLE;
                    clr_emit_next = 1'b0;
                    if (clr_emit_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_CLEARED;
                        slot_next   = '0;
                        total_next  = '0;
                    end
                end
            end
            S_DENSE:
            begin
                if (32'(daddr) >= 32'(POOL_ENTRIES))
                begin
                    done_next   = 1'b1;
                    status_next = ST_DROPPED;
                    slot_next   = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    vm_re      = 1'b1;
                    vm_raddr   = IDX_W'(32'(daddr));
                    ent_next   = IDX_W'(32'(daddr));
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                vm_we       = 1'b1;
                vm_waddr    = ent_reg;
                vm_wdata    = sum;
                done_next   = 1'b1;
                status_next = ST_ADDED;
                slot_next   = ent_w[11:0];
                total_next  = sum;
                state_next  = S_IDLE;
            end
            S_WALK:
            begin
                if (link_reg != '0 && link_reg <= count_reg)
                begin
                    lm_re      = 1'b1;
                    vm_re      = 1'b1;
                    ent_next   = link_w[IDX_W-1:0];
                    state_next = S_WCHK;
                end
                else if (count_reg == LINK_W'(POOL_ENTRIES))
                begin
                    done_next   = 1'b1;
                    status_next = ST_DROPPED;
                    slot_next   = '0;
                    total_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_WCHK:
            begin
                if (lm_rdata[LW-1:LINK_W] == fi_reg)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    tail_next  = link_reg;
                    link_next  = lm_rdata[LINK_W-1:0];
                    state_next = S_WALK;
                end
            end
            S_APPEND:
            begin
                lm_we       = 1'b1;
                lm_waddr    = LA_W'(count_w[IDX_W-1:0]);
                lm_wdata    = {fi_reg, {LINK_W{1'b0}}};
                vm_we       = 1'b1;
                vm_waddr    = count_w[IDX_W-1:0];
                vm_wdata    = v_reg;
                done_next   = 1'b1;
                status_next = ST_NEW;
                slot_next   = count_w[11:0];
                total_next  = v_reg;
                count_next  = count_reg + LINK_W'(1);
                state_next  = S_LINK;
            end
            S_LINK:
            begin
                lm_we = 1'b1;
                if (tail_reg == '0)
                begin
                    head_set = 1'b1;
                    lm_waddr = head_addr;
                    lm_wdata = {6'd0, count_reg};
                end
                else
                begin
                    // tail entry is still in the read register, keep its tag
                    lm_waddr = LA_W'(ent_reg);
                    lm_wdata = {lm_rdata[LW-1:LINK_W], count_reg};
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_emit_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            head_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_emit_reg <= clr_emit_next;
            clr_cnt_reg  <= clr_cnt_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            if (head_clr)
            begin
                head_vld_reg <= '0;
            end
            else if (head_set)
            begin
                head_vld_reg[head_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        link_reg   <= link_next;
        tail_reg   <= tail_next;
        ent_reg    <= ent_next;
        fi_reg     <= fi_next;
        si_reg     <= si_next;
        v_reg      <= v_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        total_reg  <= total_next;
    end

    // in the link state ent_reg must name the tail entry
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;
    assign total  = total_reg;

endmodule
